@@ sv/lcs_pkg.sv @@
// Shared types and constants for the LRU cache hit/miss unit.
// No dependencies; lcs_front, lcs_back and the top level import this package.
package lcs_pkg;

  // Configuration register file contents, fixed field widths.
  typedef struct packed {
    logic [31:0] index_mask;
    logic [3:0]  index_length;
    logic [4:0]  offset_bits;
    logic [3:0]  ways_used;
  } lcs_cfg_t;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_IDX_W  = 2;

  // Register indexes, taken from paddr[3:2].
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED    = 2'd3;

  localparam logic [3:0] WAYS_USED_RST = 4'd1;

  // Width of an index length once saturated to SET_BITS.
  localparam int LEN_W = 5;

endpackage

@@ sv/lcs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lcs_queue.sv @@
// Small register FIFO that decouples the classify front from the lookup back.
// No dependencies.
module lcs_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign head_data = mem_r[rp_r];
  assign full      = (cnt_r == CW'(DEPTH));
  assign empty     = (cnt_r == '0);

endmodule

@@ sv/lcs_front.sv @@
// Front end: accepts address transactions, forms the set index and the line key.
// Depends on lcs_pkg; feeds lcs_queue.
module lcs_front #(
  parameter int SET_BITS  = 10,
  parameter int ADDR_BITS = 32,
  parameter int IDX_W     = (SET_BITS > 0) ? SET_BITS : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lcs_pkg::lcs_cfg_t     cfg,
  input  logic                  remap,
  input  logic                  hold,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_address,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [IDX_W-1:0]      q_set,
  output logic [ADDR_BITS-1:0]  q_key
);
  import lcs_pkg::*;

  localparam int CW = $clog2(ADDR_BITS + 1);

  localparam logic [1:0] F_LOAD  = 2'd0;
  localparam logic [1:0] F_SWEEP = 2'd1;
  localparam logic [1:0] F_READY = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        left_r, left_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_BITS-1:0] msk_r, msk_nxt;
  logic [ADDR_BITS-1:0] en_r, en_nxt;
  logic [IDX_W-1:0]     tgt_r [ADDR_BITS];
  logic [IDX_W-1:0]     tgt_nxt [ADDR_BITS];
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     diff;
  logic                 take;

  // The map tells, for every address bit, whether it feeds the index and at
  // which index position. It is rebuilt one address bit per cycle, from the
  // top bit down, whenever the mask or the length changes.
  always_comb begin
    len = (LEN_W'(cfg.index_length) > LEN_W'(SET_BITS)) ? LEN_W'(SET_BITS)
                                                         : LEN_W'(cfg.index_length);
    take      = msk_r[ADDR_BITS-1] && (cnt_r < len);
    diff      = len - LEN_W'(1) - cnt_r;
    state_nxt = state_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    msk_nxt   = msk_r;
    en_nxt    = en_r;
    for (int i = 0; i < ADDR_BITS; i++) begin
      tgt_nxt[i] = tgt_r[i];
    end
    case (state_r)
      F_LOAD: begin
        msk_nxt   = cfg.index_mask[ADDR_BITS-1:0];
        cnt_nxt   = '0;
        left_nxt  = CW'(ADDR_BITS);
        state_nxt = F_SWEEP;
      end
      F_SWEEP: begin
        en_nxt[0]  = take;
        tgt_nxt[0] = IDX_W'(diff);
        for (int i = 1; i < ADDR_BITS; i++) begin
          en_nxt[i]  = en_r[i-1];
          tgt_nxt[i] = tgt_r[i-1];
        end
        msk_nxt  = msk_r << 1;
        cnt_nxt  = take ? cnt_r + LEN_W'(1) : cnt_r;
        left_nxt = left_r - CW'(1);
        if (left_r == CW'(1)) begin
          state_nxt = F_READY;
        end
      end
      F_READY: begin
        state_nxt = F_READY;
      end
      default: begin
        state_nxt = F_LOAD;
      end
    endcase
    if (remap) begin
      state_nxt = F_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_LOAD;
      en_r    <= '0;
    end else begin
      state_r <= state_nxt;
      en_r    <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    cnt_r  <= cnt_nxt;
    msk_r  <= msk_nxt;
    for (int i = 0; i < ADDR_BITS; i++) begin
      tgt_r[i] <= tgt_nxt[i];
    end
  end

  // Gather the index bits and clear the offset bits of the key.
  always_comb begin
    for (int k = 0; k < IDX_W; k++) begin
      q_set[k] = 1'b0;
      for (int b = 0; b < ADDR_BITS; b++) begin
        q_set[k] = q_set[k] | (en_r[b] & in_address[b] & (tgt_r[b] == IDX_W'(k)));
      end
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      q_key[i] = in_address[i] & (6'(i) >= {1'b0, cfg.offset_bits});
    end
  end

  assign in_ready = (state_r == F_READY) && !hold && !q_full;
  assign q_push   = in_valid && in_ready;

endmodule

@@ sv/lcs_back.sv @@
// Back end: reads one set row, decides hit, fill or eviction, updates LRU ranks.
// Depends on lcs_pkg and lcs_ram; drains lcs_queue.
module lcs_back #(
  parameter int WAYS      = 8,
  parameter int SET_BITS  = 10,
  parameter int ADDR_BITS = 32,
  parameter int IDX_W     = (SET_BITS > 0) ? SET_BITS : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcs_pkg::lcs_cfg_t    cfg,
  input  logic                 q_empty,
  input  logic [IDX_W-1:0]     q_set,
  input  logic [ADDR_BITS-1:0] q_key,
  output logic                 q_pop,
  output logic                 clr_busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit
);
  import lcs_pkg::*;

  localparam int NSETS  = 1 << SET_BITS;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MW     = RANK_W + 1;
  localparam int NW_W   = 5;

  localparam logic [1:0] B_CLR = 2'd0;
  localparam logic [1:0] B_RD  = 2'd1;
  localparam logic [1:0] B_UPD = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [IDX_W-1:0]       set_r;
  logic [ADDR_BITS-1:0]   key_r;
  logic                   out_v_r, out_v_nxt;
  logic                   out_hit_r;
  logic                   fire;

  logic [WAYS*ADDR_BITS-1:0] tag_row, tag_wr;
  logic [WAYS*MW-1:0]        meta_row, meta_wr, meta_wdata;
  logic                      tag_we, meta_we;
  logic [IDX_W-1:0]          meta_waddr;

  logic [ADDR_BITS-1:0] tag_w [WAYS];
  logic [RANK_W-1:0]    rnk [WAYS];
  logic [WAYS-1:0]      vld, inuse;
  logic [NW_W-1:0]      nw;
  logic                 hit_f, free_f, vic_f, age_all;
  logic [WAY_W-1:0]     hit_w, free_w, vic_w, sel_w;
  logic [RANK_W-1:0]    vic_rank, old_rank;

  lcs_ram #(.WIDTH(WAYS*ADDR_BITS), .DEPTH(NSETS), .AW(IDX_W)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (tag_wr),
    .re    (q_pop),
    .raddr (q_set),
    .rdata (tag_row)
  );

  lcs_ram #(.WIDTH(WAYS*MW), .DEPTH(NSETS), .AW(IDX_W)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (q_pop),
    .raddr (q_set),
    .rdata (meta_row)
  );

  // Lookup and replacement decision on the row read when the transaction was popped.
  always_comb begin
    if (cfg.ways_used == '0) begin
      nw = NW_W'(1);
    end else if (NW_W'(cfg.ways_used) > NW_W'(WAYS)) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(cfg.ways_used);
    end
    for (int w = 0; w < WAYS; w++) begin
      tag_w[w] = tag_row[w*ADDR_BITS +: ADDR_BITS];
      rnk[w]   = meta_row[w*MW +: RANK_W];
      vld[w]   = meta_row[w*MW + RANK_W];
      inuse[w] = NW_W'(w) < nw;
    end
    hit_f    = 1'b0;
    hit_w    = '0;
    free_f   = 1'b0;
    free_w   = '0;
    vic_f    = 1'b0;
    vic_w    = '0;
    vic_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_f && inuse[w] && vld[w] && (tag_w[w] == key_r)) begin
        hit_f = 1'b1;
        hit_w = WAY_W'(w);
      end
      if (!free_f && inuse[w] && !vld[w]) begin
        free_f = 1'b1;
        free_w = WAY_W'(w);
      end
      if (inuse[w] && vld[w] && (!vic_f || (rnk[w] > vic_rank))) begin
        vic_f    = 1'b1;
        vic_w    = WAY_W'(w);
        vic_rank = rnk[w];
      end
    end
    sel_w    = hit_f ? hit_w : (free_f ? free_w : vic_w);
    age_all  = !hit_f && free_f;
    old_rank = rnk[sel_w];
    tag_wr   = tag_row;
    meta_wr  = meta_row;
    for (int k = 0; k < WAYS; k++) begin
      if (WAY_W'(k) == sel_w) begin
        tag_wr[k*ADDR_BITS +: ADDR_BITS] = key_r;
        meta_wr[k*MW +: MW]              = {1'b1, RANK_W'(0)};
      end else if (inuse[k] && vld[k] && (age_all || (rnk[k] < old_rank))
                   && (rnk[k] != RANK_W'(WAYS - 1))) begin
        meta_wr[k*MW +: RANK_W] = rnk[k] + RANK_W'(1);
      end
    end
  end

  // Sequencer: clearing pass after reset, then read and write back per set.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    fire      = 1'b0;
    q_pop     = 1'b0;
    case (state_r)
      B_CLR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NSETS - 1)) begin
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_UPD;
        end
      end
      B_UPD: begin
        if (!out_v_r || out_ready) begin
          fire      = 1'b1;
          state_nxt = B_RD;
        end
      end
      default: begin
        state_nxt = B_CLR;
      end
    endcase
    out_v_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  assign tag_we     = fire;
  assign meta_we    = fire || (state_r == B_CLR);
  assign meta_waddr = (state_r == B_CLR) ? clr_r : set_r;
  assign meta_wdata = (state_r == B_CLR) ? '0 : meta_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      set_r <= q_set;
      key_r <= q_key;
    end
    if (fire) begin
      out_hit_r <= hit_f;
    end
  end

  assign clr_busy  = (state_r == B_CLR);
  assign out_valid = out_v_r;
  assign out_hit   = out_hit_r;

endmodule

@@ sv/lru_cache_hit_miss_sim_unit.sv @@
// Top level of the set-associative LRU cache hit/miss unit, with its register file.
// Depends on lcs_pkg, lcs_front, lcs_queue and lcs_back (which uses lcs_ram).
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_address[31:0]
//   out_      output     out_valid / out_ready  out_hit
//   cfg_      APB slave  psel, penable, pready  paddr[3:0], pwdata/prdata[31:0]
//
// In the lookup engine each transaction first reads the set row of tags and LRU
// ranks, then decides and writes the row back. Because of the single read-then-write
// of the set row, a new transaction is not taken before the last one is written back.
// After reset the block accepts nothing while the valid bits and ranks are cleared
// one set per cycle. A write to index_mask or index_length rebuilds the index bit
// map, during which in_ready is low. A stalled output holds in a register while
// up to two more transactions wait in the queue behind the front end.
module lru_cache_hit_miss_sim_unit #(
  parameter int WAYS      = 8,
  parameter int SET_BITS  = 10,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     in_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [lcs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import lcs_pkg::*;

  localparam int IDX_W = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int QW    = IDX_W + ADDR_BITS;

  lcs_cfg_t              cfg_r, cfg_nxt;
  logic                  cfg_wr;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic                  remap;

  logic                  q_push, q_pop, q_full, q_empty;
  logic [IDX_W-1:0]      push_set, head_set;
  logic [ADDR_BITS-1:0]  push_key, head_key;
  logic [QW-1:0]         head_data;
  logic                  clr_busy;

  // Register file. The write lands at the access phase of an APB transaction.
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_INDEX_MASK:   cfg_nxt.index_mask   = cfg_pwdata;
        REG_INDEX_LENGTH: cfg_nxt.index_length = cfg_pwdata[3:0];
        REG_OFFSET_BITS:  cfg_nxt.offset_bits  = cfg_pwdata[4:0];
        REG_WAYS_USED:    cfg_nxt.ways_used    = cfg_pwdata[3:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.index_mask   <= '0;
      cfg_r.index_length <= '0;
      cfg_r.offset_bits  <= '0;
      cfg_r.ways_used    <= WAYS_USED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INDEX_MASK:   cfg_prdata = cfg_r.index_mask;
      REG_INDEX_LENGTH: cfg_prdata = {28'd0, cfg_r.index_length};
      REG_OFFSET_BITS:  cfg_prdata = {27'd0, cfg_r.offset_bits};
      REG_WAYS_USED:    cfg_prdata = {28'd0, cfg_r.ways_used};
      default:          cfg_prdata = '0;
    endcase
  end

  // The index bit map depends on the mask and the length only.
  assign remap = cfg_wr && ((reg_idx == REG_INDEX_MASK) || (reg_idx == REG_INDEX_LENGTH));

  lcs_front #(.SET_BITS(SET_BITS), .ADDR_BITS(ADDR_BITS), .IDX_W(IDX_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .remap      (remap),
    .hold       (clr_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_address (in_address),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_set      (push_set),
    .q_key      (push_key)
  );

  lcs_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_set, push_key}),
    .pop       (q_pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_set = head_data[QW-1:ADDR_BITS];
  assign head_key = head_data[ADDR_BITS-1:0];

  lcs_back #(
    .WAYS      (WAYS),
    .SET_BITS  (SET_BITS),
    .ADDR_BITS (ADDR_BITS),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_set     (head_set),
    .q_key     (head_key),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

endmodule
